>>> hw/rtl/fctr_pkg.sv
// types and constants shared by the filtered trace ring
package fctr_pkg;

  localparam logic [1:0] OP_STORE = 2'd0;
  localparam logic [1:0] OP_AMEND = 2'd1;
  localparam logic [1:0] OP_SEEK  = 2'd2;
  localparam logic [1:0] OP_NEXT  = 2'd3;

  localparam logic       CFG_FILTER = 1'b0;
  localparam logic       CFG_HALT   = 1'b1;

  localparam logic [2:0] ORIGIN_INVALID = 3'd7;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] cycle_stamp;
    logic [15:0] pc_address;
    logic [7:0]  opcode;
    logic [15:0] operand_bytes;
    logic [7:0]  acc_value;
    logic [7:0]  xreg_value;
    logic [7:0]  yreg_value;
    logic [7:0]  stack_value;
    logic [7:0]  flags_value;
    logic [2:0]  origin_space;
    logic [11:0] back_count;
  } fctr_in_t;

  typedef struct packed {
    logic        hit;
    logic [11:0] position;
    logic [63:0] out_cycle;
    logic [15:0] out_address;
    logic [7:0]  out_opcode;
    logic [15:0] out_operands;
    logic [7:0]  out_acc;
    logic [7:0]  out_xreg;
    logic [7:0]  out_yreg;
    logic [7:0]  out_stack;
    logic [7:0]  out_flags;
    logic [2:0]  out_origin;
  } fctr_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_FETCH,
    ST_DONE
  } fctr_state_t;

endpackage

>>> hw/rtl/filtered_cpu_trace_ring_unit.sv
// filtered cpu trace ring: top level with entry memories and walk sequencer
//
//  channel | ports                          | handshake
//  input   | start, busy, in_item           | taken when start & !busy
//  result  | out_valid, out_item            | one-cycle strobe, no stall
//  config  | cfg_we, cfg_index, cfg_wdata   | written when cfg_we
//
// store and amend do their memory read/write in ST_DONE, then the result is registered
// seek and next walk one slot per cycle through the origin memory port
// after reset a clearing pass marks every origin invalid;
//   busy is high meanwhile
// results cannot be stalled
module filtered_cpu_trace_ring_unit
  import fctr_pkg::*;
#(
  parameter int DEPTH = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  fctr_in_t  in_item,
  output logic      out_valid,
  output fctr_out_t out_item,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [6:0] cfg_wdata
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [63:0] mem_cyc [DEPTH];
  logic [39:0] mem_ins [DEPTH];
  logic [39:0] mem_reg [DEPTH];
  logic [2:0]  mem_org [DEPTH];

  fctr_state_t state_r, state_nxt;
  fctr_in_t    item_r;
  logic [AW-1:0] wslot_r, wslot_nxt;
  logic [AW-1:0] cursor_r, cursor_nxt;
  logic [AW-1:0] walk_r, walk_nxt;
  logic [11:0]   found_r, found_nxt;
  logic [11:0]   count_r;
  logic [6:0]    filter_r;
  logic          halt_r;
  logic          hit_r, hit_nxt;
  logic          pend_r, pend_nxt;   // origin read of walk_r in flight
  logic          done_r;
  fctr_out_t     res_nxt;

  logic [2:0]  org_rd;
  logic [63:0] cyc_rd;
  logic [39:0] ins_rd;
  logic [39:0] reg_rd;

  logic [AW-1:0] oldest;
  logic [AW-1:0] walk_dn, walk_up;
  logic          match;
  logic          accept;

  // memory port control
  logic          org_we;
  logic [AW-1:0] org_wa;
  logic [2:0]    org_wd;
  logic          ent_we;
  logic          ins_we;
  logic [39:0]   ins_wd;
  logic [AW-1:0] rd_a;

  assign accept  = start && !busy;
  assign busy    = (state_r != ST_IDLE);
  assign oldest  = (wslot_r == LAST) ? '0 : wslot_r + 1'b1;
  assign walk_dn = (walk_r == '0) ? LAST : walk_r - 1'b1;
  assign walk_up = (walk_r == LAST) ? '0 : walk_r + 1'b1;
  assign match   = (org_rd != ORIGIN_INVALID) && filter_r[org_rd];

  always_ff @(posedge clk) begin
    if (org_we) mem_org[org_wa] <= org_wd;
    org_rd <= mem_org[rd_a];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      mem_cyc[wslot_r] <= item_r.cycle_stamp;
      mem_reg[wslot_r] <= {item_r.flags_value, item_r.stack_value, item_r.yreg_value,
                           item_r.xreg_value, item_r.acc_value};
    end
    if (ins_we) mem_ins[wslot_r] <= ins_wd;
    cyc_rd <= mem_cyc[rd_a];
    ins_rd <= mem_ins[rd_a];
    reg_rd <= mem_reg[rd_a];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r <= 7'd1;
      halt_r   <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FILTER) filter_r <= cfg_wdata;
      else halt_r <= cfg_wdata[0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (walk_r == LAST) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (in_item.operation == OP_SEEK || in_item.operation == OP_NEXT)
            state_nxt = ST_WALK;
          else
            state_nxt = ST_DONE;
        end
      end
      ST_WALK: begin
        if (item_r.operation == OP_SEEK) begin
          if (found_r >= count_r) state_nxt = ST_DONE;
          else if (pend_r && walk_dn == oldest) state_nxt = ST_DONE;
        end else begin
          if (!pend_r && walk_r == oldest) state_nxt = ST_DONE;
          else if (pend_r && match) state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    wslot_nxt  = wslot_r;
    cursor_nxt = cursor_r;
    walk_nxt   = walk_r;
    found_nxt  = found_r;
    hit_nxt    = hit_r;
    pend_nxt   = 1'b0;
    org_we     = 1'b0;
    org_wa     = walk_r;
    org_wd     = ORIGIN_INVALID;
    ent_we     = 1'b0;
    ins_we     = 1'b0;
    ins_wd     = ins_rd;
    rd_a       = walk_r;
    case (state_r)
      ST_CLEAR: begin
        org_we   = 1'b1;
        walk_nxt = walk_r + 1'b1;
      end
      ST_IDLE: begin
        found_nxt = '0;
        hit_nxt   = 1'b0;
        rd_a      = wslot_r;
        if (accept) begin
          if (in_item.operation == OP_SEEK) begin
            walk_nxt = wslot_r;
            pend_nxt = 1'b1;
          end else if (in_item.operation == OP_NEXT) begin
            walk_nxt = (cursor_r == LAST) ? '0 : cursor_r + 1'b1;
          end else if (in_item.operation == OP_STORE && !halt_r) begin
            // store bumps the write slot at the start so the entry lands there
            wslot_nxt = oldest;
          end
        end
      end
      ST_WALK: begin
        if (item_r.operation == OP_SEEK) begin
          if (found_r < count_r) begin
            if (!pend_r) begin
              pend_nxt = 1'b1;
            end else begin
              if (match) found_nxt = found_r + 1'b1;
              walk_nxt = walk_dn;
              rd_a     = walk_dn;
              pend_nxt = 1'b1;
              if (walk_dn == oldest) cursor_nxt = walk_dn;
            end
          end else begin
            cursor_nxt = walk_r;
          end
        end else begin
          if (!pend_r) begin
            if (walk_r != oldest) pend_nxt = 1'b1;
          end else if (match) begin
            hit_nxt    = 1'b1;
            cursor_nxt = walk_r;
          end else begin
            walk_nxt = walk_up;
            rd_a     = walk_up;
            pend_nxt = (walk_up != oldest);
          end
        end
      end
      ST_FETCH: rd_a = walk_r;
      ST_DONE: begin
        if (item_r.operation == OP_STORE && !halt_r) begin
          ent_we = 1'b1;
          ins_we = 1'b1;
          ins_wd = {item_r.operand_bytes, item_r.opcode, item_r.pc_address};
          org_we = 1'b1;
          org_wa = wslot_r;
          org_wd = item_r.origin_space;
        end else if (item_r.operation == OP_AMEND) begin
          ins_we = 1'b1;
          ins_wd = {item_r.operand_bytes[15:8], ins_rd[31:0]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      wslot_r  <= '0;
      cursor_r <= '0;
      walk_r   <= '0;
      found_r  <= '0;
      hit_r    <= 1'b0;
      pend_r   <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wslot_r  <= wslot_nxt;
      cursor_r <= cursor_nxt;
      walk_r   <= walk_nxt;
      found_r  <= found_nxt;
      hit_r    <= hit_nxt;
      pend_r   <= pend_nxt;
      done_r   <= (state_r == ST_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r  <= in_item;
      count_r <= (int'(in_item.back_count) > DEPTH - 1) ? 12'(DEPTH - 1)
                                                        : in_item.back_count;
    end
  end

  // result value
  always_comb begin
    res_nxt          = '0;
    res_nxt.hit      = hit_r;
    res_nxt.position = 12'((item_r.operation == OP_STORE ||
                            item_r.operation == OP_AMEND) ? wslot_r : cursor_r);
    if (hit_r) begin
      res_nxt.out_cycle    = cyc_rd;
      res_nxt.out_address  = ins_rd[15:0];
      res_nxt.out_opcode   = ins_rd[23:16];
      res_nxt.out_operands = ins_rd[39:24];
      res_nxt.out_acc      = reg_rd[7:0];
      res_nxt.out_xreg     = reg_rd[15:8];
      res_nxt.out_yreg     = reg_rd[23:16];
      res_nxt.out_stack    = reg_rd[31:24];
      res_nxt.out_flags    = reg_rd[39:32];
      res_nxt.out_origin   = org_rd;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE) out_item <= res_nxt;
  end

  assign out_valid = done_r;

endmodule

>>> hw/rtl/fctr_checker.sv
// port-level checks for the filtered trace ring
module fctr_checker
  import fctr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input fctr_out_t out_item
);

  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$past(out_valid))
    else $error("back to back results");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("item taken but not busy");

  a_result_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy with result out");

  a_hit_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.hit) |-> (out_item.out_cycle == 64'd0))
    else $error("miss carries data");

endmodule

bind filtered_cpu_trace_ring_unit fctr_checker u_fctr_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);
